### design/rmfh_pkg.sv
// Shared types, status codes and defaults for the recursive mutex lock manager.
package rmfh_pkg;

  localparam int WAIT_SLOTS_DEF = 16;
  localparam int MAX_DEPTH_DEF  = 255;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [3:0] ST_GRANTED    = 4'd0;
  localparam logic [3:0] ST_REENTERED  = 4'd1;
  localparam logic [3:0] ST_QUEUED     = 4'd2;
  localparam logic [3:0] ST_FREED      = 4'd3;
  localparam logic [3:0] ST_HANDED_OFF = 4'd4;
  localparam logic [3:0] ST_LOWERED    = 4'd5;
  localparam logic [3:0] ST_DEPTH_LIM  = 4'd6;
  localparam logic [3:0] ST_NOT_HOLDER = 4'd7;
  localparam logic [3:0] ST_QUEUE_FULL = 4'd8;

  typedef struct packed {
    logic       opcode;
    logic [7:0] thread_id;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic       owner_valid;
    logic [7:0] owner_id;
    logic [7:0] depth;
    logic [4:0] waiting_count;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

### design/rmfh_ctrl.sv
// Sequencing FSM: accepts a beat, schedules the update, manages the output beat.
module rmfh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output rmfh_pkg::ctrl_cmd_t cmd
);
  import rmfh_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_blocked;

  assign out_blocked = out_valid_r && out_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;

  always_comb begin
    cmd.capture   = 1'b0;
    cmd.commit    = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_blocked;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_blocked) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/rmfh_dpath.sv
// Owner, depth and wait-queue state with the request decode and result register.
module rmfh_dpath #(
  parameter int WAIT_SLOTS = rmfh_pkg::WAIT_SLOTS_DEF,
  parameter int MAX_DEPTH  = rmfh_pkg::MAX_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rmfh_pkg::ctrl_cmd_t cmd,
  input  rmfh_pkg::in_item_t  in_data,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  output rmfh_pkg::out_item_t out_data
);
  import rmfh_pkg::*;

  localparam int PTR_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int CNT_W = $clog2(WAIT_SLOTS + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WAIT_SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WAIT_SLOTS);
  localparam logic [7:0]       MAX_D     = 8'(MAX_DEPTH);

  logic [7:0] wait_mem [WAIT_SLOTS];
  logic [7:0] head_data_r;

  logic             mode_r;
  in_item_t         req_r;
  logic             owner_flag_r, owner_flag_nxt;
  logic [7:0]       owner_r, owner_nxt;
  logic [7:0]       depth_r, depth_nxt;
  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [3:0]       status;
  logic             push;
  logic             is_holder;
  logic [7:0]       limit;
  out_item_t        out_r;

  assign is_holder = owner_flag_r && (owner_r == req_r.thread_id);
  assign limit     = mode_r ? MAX_D : 8'd1;
  assign out_data  = out_r;

  always_comb begin
    owner_flag_nxt = owner_flag_r;
    owner_nxt      = owner_r;
    depth_nxt      = depth_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    push           = 1'b0;
    status         = ST_NOT_HOLDER;
    if (req_r.opcode == OP_ACQUIRE) begin
      if (!owner_flag_r) begin
        owner_flag_nxt = 1'b1;
        owner_nxt      = req_r.thread_id;
        depth_nxt      = 8'd1;
        status         = ST_GRANTED;
      end else if (is_holder) begin
        if (depth_r < limit) begin
          depth_nxt = depth_r + 8'd1;
          status    = ST_REENTERED;
        end else begin
          status = ST_DEPTH_LIM;
        end
      end else if (count_r < FULL_CNT) begin
        push      = 1'b1;
        tail_nxt  = (tail_r == LAST_SLOT) ? '0 : tail_r + PTR_W'(1);
        count_nxt = count_r + CNT_W'(1);
        status    = ST_QUEUED;
      end else begin
        status = ST_QUEUE_FULL;
      end
    end else begin
      if (!is_holder) begin
        status = ST_NOT_HOLDER;
      end else if (depth_r > 8'd1) begin
        depth_nxt = depth_r - 8'd1;
        status    = ST_LOWERED;
      end else if (count_r != '0) begin
        owner_nxt = head_data_r;
        head_nxt  = (head_r == LAST_SLOT) ? '0 : head_r + PTR_W'(1);
        count_nxt = count_r - CNT_W'(1);
        depth_nxt = 8'd1;
        status    = ST_HANDED_OFF;
      end else begin
        owner_flag_nxt = 1'b0;
        owner_nxt      = 8'd0;
        depth_nxt      = 8'd0;
        status         = ST_FREED;
      end
    end
  end

  // head read is registered every cycle; the commit uses last cycle's sample
  always_ff @(posedge clk) begin
    head_data_r <= wait_mem[head_r];
    if (cmd.commit && push) begin
      wait_mem[tail_r] <= req_r.thread_id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.commit) begin
      out_r.status        <= status;
      out_r.owner_valid   <= owner_flag_nxt;
      out_r.owner_id      <= owner_flag_nxt ? owner_nxt : 8'd0;
      out_r.depth         <= owner_flag_nxt ? depth_nxt : 8'd0;
      out_r.waiting_count <= 5'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      owner_flag_r <= 1'b0;
      owner_r      <= 8'd0;
      depth_r      <= 8'd0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
    end else begin
      if (cfg_valid) begin
        mode_r <= cfg_data;
      end
      if (cmd.commit) begin
        owner_flag_r <= owner_flag_nxt;
        owner_r      <= owner_nxt;
        depth_r      <= depth_nxt;
        head_r       <= head_nxt;
        tail_r       <= tail_nxt;
        count_r      <= count_nxt;
      end
    end
  end

endmodule

### design/recursive_mutex_fifo_handoff_top.sv
// Top level: recursive mutex manager with FIFO handoff of waiting threads.
// The result beat is registered on the commit in S_EXEC, which waits while an earlier result beat is stalled.
// A new input beat is taken only in S_IDLE, once the capture-then-commit sequence of the controller is done.
// A stalled result holds back the next update; one further input beat may be taken meanwhile.
// Synchronous active-low reset frees the lock, empties the queue, clears recursive_mode.
// Queue entries are not cleared; only written entries are ever used for a handoff.
module recursive_mutex_fifo_handoff_top #(
  parameter int WAIT_SLOTS = rmfh_pkg::WAIT_SLOTS_DEF,
  parameter int MAX_DEPTH  = rmfh_pkg::MAX_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmfh_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rmfh_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import rmfh_pkg::*;

  ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  rmfh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rmfh_dpath #(
    .WAIT_SLOTS (WAIT_SLOTS),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

### design/rmfh_checker.sv
// Port-level checks for the lock manager, bound to the top level.
module rmfh_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rmfh_pkg::out_item_t out_data
);
  import rmfh_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_free_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.owner_valid |-> out_data.owner_id == 8'd0 && out_data.depth == 8'd0)
    else $error("free lock reports owner or depth");

  a_owned_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.owner_valid |-> out_data.depth != 8'd0)
    else $error("owned lock with zero depth");

  a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken before result issued");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_QUEUE_FULL)
    else $error("undefined status code");

endmodule

bind recursive_mutex_fifo_handoff_top rmfh_checker u_rmfh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### bench/tb_recursive_mutex_fifo_handoff_top.sv
// Self-checking bench for the recursive mutex manager: directed and random lock beats vs. a lock predictor.
module tb_recursive_mutex_fifo_handoff_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rmfh_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  recursive_mutex_fifo_handoff_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  in_item_t  lock_ops_q[$];
  out_item_t lock_results_q[$];
  int        err_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      hold_arm = 1'b0;
  int        hold_left = 0;

  // lock state as seen by the predictor
  logic       lk_mode = 1'b0;
  logic       lk_owned = 1'b0;
  logic [7:0] lk_owner = '0;
  int         lk_depth = 0;
  logic [7:0] lk_waiters[$];

  task automatic apply_lock_op(input in_item_t op, output out_item_t res);
    int   limit;
    logic holder;
    limit  = lk_mode ? MAX_DEPTH_DEF : 1;
    holder = lk_owned && (lk_owner == op.thread_id);
    if (op.opcode == OP_ACQUIRE) begin
      if (!lk_owned) begin
        lk_owned = 1'b1;
        lk_owner = op.thread_id;
        lk_depth = 1;
        res.status = ST_GRANTED;
      end else if (holder) begin
        if (lk_depth < limit) begin
          lk_depth++;
          res.status = ST_REENTERED;
        end else begin
          res.status = ST_DEPTH_LIM;
        end
      end else if (lk_waiters.size() < WAIT_SLOTS_DEF) begin
        lk_waiters.push_back(op.thread_id);
        res.status = ST_QUEUED;
      end else begin
        res.status = ST_QUEUE_FULL;
      end
    end else begin
      if (!holder) begin
        res.status = ST_NOT_HOLDER;
      end else if (lk_depth > 1) begin
        lk_depth--;
        res.status = ST_LOWERED;
      end else if (lk_waiters.size() != 0) begin
        lk_owner = lk_waiters.pop_front();
        lk_depth = 1;
        res.status = ST_HANDED_OFF;
      end else begin
        lk_owned = 1'b0;
        lk_owner = '0;
        lk_depth = 0;
        res.status = ST_FREED;
      end
    end
    res.owner_valid   = lk_owned;
    res.owner_id      = lk_owned ? lk_owner : 8'd0;
    res.depth         = lk_owned ? 8'(lk_depth) : 8'd0;
    res.waiting_count = 5'(lk_waiters.size());
  endtask

  // input driver
  always @(posedge clk) begin : lock_driver
    out_item_t pred;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_lock_op(in_data, pred);
        lock_results_q.push_back(pred);
      end
      if (!in_valid || !in_stall) begin
        if (lock_ops_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= lock_ops_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= 200;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin : lock_monitor
    out_item_t exp_res;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (lock_results_q.size() == 0) begin
          $error("unexpected result beat: status %0d", out_data.status);
          err_count++;
        end else begin
          exp_res = lock_results_q.pop_front();
          if (out_data.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_data.status);
            err_count++;
          end
          if (out_data.owner_valid !== exp_res.owner_valid) begin
            $error("owner_valid: expected %0d, got %0d", exp_res.owner_valid,
                   out_data.owner_valid);
            err_count++;
          end
          if (out_data.owner_id !== exp_res.owner_id) begin
            $error("owner_id: expected %0d, got %0d", exp_res.owner_id, out_data.owner_id);
            err_count++;
          end
          if (out_data.depth !== exp_res.depth) begin
            $error("depth: expected %0d, got %0d", exp_res.depth, out_data.depth);
            err_count++;
          end
          if (out_data.waiting_count !== exp_res.waiting_count) begin
            $error("waiting_count: expected %0d, got %0d", exp_res.waiting_count,
                   out_data.waiting_count);
            err_count++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic push_op(input logic op, input logic [7:0] tid);
    in_item_t it;
    it.opcode    = op;
    it.thread_id = tid;
    lock_ops_q.push_back(it);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (lock_ops_q.size() != 0 || in_valid || lock_results_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // release by whoever holds the lock until it is free and nobody waits
  task automatic free_lock();
    drain();
    while (lk_owned) begin
      repeat (lk_depth) push_op(OP_RELEASE, lk_owner);
      drain();
    end
  endtask

  task automatic write_mode(input logic mode);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    lk_mode = mode;
    @(negedge clk);
  endtask

  // mix of clean acquire/release sessions and loose traffic
  task automatic gen_random(input int n);
    logic [7:0] pool[4];
    logic [7:0] t;
    int         k;
    int         cnt;
    foreach (pool[j]) pool[j] = 8'($urandom_range(255));
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(99) < 30) begin
        t = pool[$urandom_range(3)];
        k = $urandom_range(1, 3);
        repeat (k) push_op(OP_ACQUIRE, t);
        repeat (k) push_op(OP_RELEASE, t);
        cnt += 2 * k;
      end else begin
        t = ($urandom_range(99) < 80) ? pool[$urandom_range(3)] : 8'($urandom_range(255));
        push_op(($urandom_range(99) < 55) ? OP_ACQUIRE : OP_RELEASE, t);
        cnt++;
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] deep_tid;
    send_idle_pct = 10;
    recv_idle_pct = 83;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(1'b0);

    // directed, depth limit 1
    push_op(OP_ACQUIRE, 8'h00);
    push_op(OP_ACQUIRE, 8'h00);
    push_op(OP_RELEASE, 8'h55);
    push_op(OP_RELEASE, 8'h00);
    push_op(OP_RELEASE, 8'h00);
    push_op(OP_ACQUIRE, 8'hFF);
    for (int i = 1; i <= WAIT_SLOTS_DEF; i++) push_op(OP_ACQUIRE, 8'(i * 13));
    push_op(OP_ACQUIRE, 8'hAA);
    free_lock();

    // recursive mode, climb to the depth limit and back
    write_mode(1'b1);
    deep_tid = 8'($urandom_range(255));
    repeat (MAX_DEPTH_DEF + 1) push_op(OP_ACQUIRE, deep_tid);
    repeat (4) push_op(OP_ACQUIRE, deep_tid ^ 8'($urandom_range(1, 255)));
    repeat (MAX_DEPTH_DEF + 1) push_op(OP_RELEASE, deep_tid);
    gen_random(60);
    free_lock();

    send_idle_pct = 83;
    recv_idle_pct = 10;
    write_mode(1'b0);
    gen_random(150);
    free_lock();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mode(1'b1);
    hold_arm = 1'b1;
    gen_random(150);
    @(negedge clk);
    hold_arm = 1'b0;
    drain();
    repeat (10) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_recursive_mutex_fifo_handoff_top OK");
    end else begin
      $display("tb_recursive_mutex_fifo_handoff_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb_recursive_mutex_fifo_handoff_top NOT OK");
    $finish;
  end

endmodule
